// File: sv/mktd_pkg.sv
// ----------------------------------------------------------------------------
// Morse key timing decoder package
// Shared types, constants and lookup functions for the decoder block.
// ----------------------------------------------------------------------------
package mktd_pkg;

	localparam int DURATION_BITS_DEFAULT = 24;
	localparam int CFG_ADDR_BITS = 4;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [31:0] DAH_RESET_US   = 32'd500000;
	localparam logic [31:0] SPACE_RESET_US = 32'd500000;
	localparam logic [31:0] END_RESET_US   = 32'd1500000;

	localparam logic [2:0] MAX_SYMBOLS = 3'd5;
	localparam logic [2:0] SAT_SYMBOLS = 3'd6;
	localparam logic [7:0] UNKNOWN_CHAR = 8'h7E;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam int CODE_COUNT = 36;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = 2;
	localparam int QUEUE_CNT_BITS = 3;

	typedef enum logic [1:0] {
		REG_DAH   = 2'd0,
		REG_SPACE = 2'd1,
		REG_END   = 2'd2
	} reg_index_t;

	typedef enum logic {
		MODE_KEY   = 1'b0,
		MODE_BREAK = 1'b1
	} mode_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_message;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	localparam logic [15:0] CODE_OF [CODE_COUNT] = '{
		16'd2150, 16'd18884, 16'd18452, 16'd7964, 16'd210, 16'd18468, 16'd7804,
		16'd18900, 16'd2310, 16'd17476, 16'd7532, 16'd18740, 16'd2134, 16'd2294,
		16'd7372, 16'd18308, 16'd17892, 16'd7820, 16'd7980, 16'd194, 16'd7548,
		16'd18068, 16'd7388, 16'd18052, 16'd17620, 16'd18724,
		16'd33950, 16'd33966, 16'd34126, 16'd34558, 16'd35390, 16'd36750,
		16'd36734, 16'd36574, 16'd36142, 16'd35310
	};

	localparam logic [7:0] CHAR_OF [CODE_COUNT] = '{
		"A", "B", "C", "D", "E", "F", "G", "H", "I", "J", "K", "L", "M",
		"N", "O", "P", "Q", "R", "S", "T", "U", "V", "W", "X", "Y", "Z",
		"0", "1", "2", "3", "4", "5", "6", "7", "8", "9"
	};

	// Symbol weight times position weight, for a dah or a dit.
	function automatic logic [15:0] sym_weight(input logic [2:0] pos, input logic dah);
		logic [15:0] w;
		unique case (pos)
			3'd0:    w = dah ? 16'd194   : 16'd210;
			3'd1:    w = dah ? 16'd1940  : 16'd2100;
			3'd2:    w = dah ? 16'd5238  : 16'd5670;
			3'd3:    w = dah ? 16'd10088 : 16'd10920;
			3'd4:    w = dah ? 16'd16490 : 16'd17850;
			default: w = 16'd0;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] lookup_letter(input logic [15:0] code,
		input logic [2:0] count);
		logic [7:0] ch;
		ch = UNKNOWN_CHAR;
		if (count != 3'd0 && count <= MAX_SYMBOLS) begin
			for (int i = 0; i < CODE_COUNT; i++) begin
				if (CODE_OF[i] == code) begin
					ch = CHAR_OF[i];
				end
			end
		end
		return ch;
	endfunction

endpackage

// File: sv/mktd_cfg_regs.sv
// ----------------------------------------------------------------------------
// Morse decoder configuration registers
// APB-style register file holding the three timing thresholds.
// ----------------------------------------------------------------------------
module mktd_cfg_regs import mktd_pkg::*; #(
	parameter int DURATION_BITS = DURATION_BITS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output logic [DURATION_BITS-1:0] dah_threshold,
	output logic [DURATION_BITS-1:0] space_threshold,
	output logic [DURATION_BITS-1:0] end_threshold
);

	logic [DURATION_BITS-1:0] dah_q;
	logic [DURATION_BITS-1:0] space_q;
	logic [DURATION_BITS-1:0] end_q;
	logic                     wr_en;
	reg_index_t               idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_index_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dah_q   <= DURATION_BITS'(DAH_RESET_US);
			space_q <= DURATION_BITS'(SPACE_RESET_US);
			end_q   <= DURATION_BITS'(END_RESET_US);
		end else if (wr_en) begin
			unique case (idx)
				REG_DAH:   dah_q   <= pwdata[DURATION_BITS-1:0];
				REG_SPACE: space_q <= pwdata[DURATION_BITS-1:0];
				REG_END:   end_q   <= pwdata[DURATION_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DAH:   prdata = CFG_DATA_BITS'(dah_q);
			REG_SPACE: prdata = CFG_DATA_BITS'(space_q);
			REG_END:   prdata = CFG_DATA_BITS'(end_q);
			default:   prdata = '0;
		endcase
	end

	assign dah_threshold   = dah_q;
	assign space_threshold = space_q;
	assign end_threshold   = end_q;

endmodule

// File: sv/mktd_decode.sv
// ----------------------------------------------------------------------------
// Morse decoder core
// Input register, letter state and the single-pass decode of one press.
// ----------------------------------------------------------------------------
module mktd_decode import mktd_pkg::*; #(
	parameter int DURATION_BITS = DURATION_BITS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     mode,
	input  logic [DURATION_BITS-1:0] press_length_us,
	input  logic [DURATION_BITS-1:0] dah_threshold,
	input  logic [DURATION_BITS-1:0] space_threshold,
	input  logic [DURATION_BITS-1:0] end_threshold,
	input  logic                     queue_room,
	output push_t                    push
);

	logic                     valid_s1;
	mode_t                    mode_s1;
	logic [DURATION_BITS-1:0] len_s1;
	logic [15:0]              letter_q;
	logic [2:0]               count_q;
	logic                     advance;
	logic [7:0]               ch;

	assign advance  = valid_s1 & ((mode_s1 == MODE_KEY) | queue_room);
	assign in_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1 <= mode_t'(mode);
			len_s1  <= press_length_us;
		end
	end

	assign ch = lookup_letter(letter_q, count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_q <= '0;
			count_q  <= '0;
		end else if (advance) begin
			if (mode_s1 == MODE_KEY) begin
				if (count_q < MAX_SYMBOLS) begin
					letter_q <= letter_q + sym_weight(count_q, len_s1 > dah_threshold);
					count_q  <= count_q + 3'd1;
				end else begin
					count_q <= SAT_SYMBOLS;
				end
			end else begin
				letter_q <= '0;
				count_q  <= '0;
			end
		end
	end

	always_comb begin
		push = '0;
		if (advance && mode_s1 == MODE_BREAK) begin
			if (len_s1 > end_threshold) begin
				push.n  = 2'd1;
				push.r0 = '{char_code: 8'd0, end_of_message: 1'b1, last: 1'b1};
			end else if (len_s1 > space_threshold) begin
				push.n  = 2'd2;
				push.r0 = '{char_code: ch, end_of_message: 1'b0, last: 1'b0};
				push.r1 = '{char_code: SPACE_CHAR, end_of_message: 1'b0, last: 1'b1};
			end else begin
				push.n  = 2'd1;
				push.r0 = '{char_code: ch, end_of_message: 1'b0, last: 1'b1};
			end
		end
	end

endmodule

// File: sv/mktd_out_queue.sv
// ----------------------------------------------------------------------------
// Morse decoder result queue
// Small queue that takes up to two results a cycle and hands out one unless out_stall is high.
// ----------------------------------------------------------------------------
module mktd_out_queue import mktd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	output logic       queue_room,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] char_code,
	output logic       end_of_message,
	output logic       last
);

	result_t                   mem [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;
	logic                      pop;

	assign out_valid  = (count_q != '0);
	assign pop        = out_valid & ~out_stall;
	assign queue_room = (count_q <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem[wr_ptr_q + QUEUE_PTR_BITS'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QUEUE_PTR_BITS'(push.n);
			rd_ptr_q <= rd_ptr_q + QUEUE_PTR_BITS'(pop);
			count_q  <= count_q + QUEUE_CNT_BITS'(push.n) - QUEUE_CNT_BITS'(pop);
		end
	end

	assign char_code      = mem[rd_ptr_q].char_code;
	assign end_of_message = mem[rd_ptr_q].end_of_message;
	assign last           = mem[rd_ptr_q].last;

`ifndef NO_ASSERTIONS
	a_room_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> queue_room)
		else $error("Results pushed into a queue without room.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
		else $error("Result queue count exceeds its depth.");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.n == 2'd0) |=> (count_q == $past(count_q) - QUEUE_CNT_BITS'(1)))
		else $error("Result queue count did not drop after a pop.");

	a_eom_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_message) |-> (last && char_code == 8'd0))
		else $error("End-of-message item is not a lone last item.");
`endif

endmodule

// File: sv/morse_key_timing_decoder_top.sv
// A result is offered once its press item has passed the input register and the
// result queue. One press item per cycle unless in_stall; a medium break yields
// two items, drained one per cycle unless out_stall by the four-entry queue.
// Reset clears the letter state and the queue, and loads the default thresholds.
// ----------------------------------------------------------------------------
// Morse key timing decoder
// Turns key and break presses into ASCII letters, spaces and message ends.
// ----------------------------------------------------------------------------
module morse_key_timing_decoder_top import mktd_pkg::*; #(
	parameter int DURATION_BITS = DURATION_BITS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     mode,
	input  logic [DURATION_BITS-1:0] press_length_us,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [7:0]               char_code,
	output logic                     end_of_message,
	output logic                     last
);

	logic [DURATION_BITS-1:0] dah_threshold;
	logic [DURATION_BITS-1:0] space_threshold;
	logic [DURATION_BITS-1:0] end_threshold;
	logic                     queue_room;
	push_t                    push;

	mktd_cfg_regs #(.DURATION_BITS(DURATION_BITS)) u_cfg (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.dah_threshold(dah_threshold), .space_threshold(space_threshold),
		.end_threshold(end_threshold)
	);

	mktd_decode #(.DURATION_BITS(DURATION_BITS)) u_decode (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .press_length_us(press_length_us),
		.dah_threshold(dah_threshold), .space_threshold(space_threshold),
		.end_threshold(end_threshold),
		.queue_room(queue_room), .push(push)
	);

	mktd_out_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .queue_room(queue_room),
		.out_valid(out_valid), .out_stall(out_stall),
		.char_code(char_code), .end_of_message(end_of_message), .last(last)
	);

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse key timing decoder testbench
// Feeds key and break presses through the valid/stall input, predicts each
// letter, space or message end from its own model of the letter state, and
// compares every item leaving the block in order. Thresholds are set over APB
// between phases and read back.
// ----------------------------------------------------------------------------
import mktd_pkg::*;

localparam int unsigned DAH_WEIGHT = 97;
localparam int unsigned DIT_WEIGHT = 105;

class morse_scoreboard;
	logic [15:0] letter_code;
	logic [2:0]  symbol_count;
	logic [23:0] dah_us;
	logic [23:0] space_us;
	logic [23:0] end_us;
	result_t     pending[$];
	int          errors;
	int          checked;

	function new();
		letter_code = '0;
		symbol_count = '0;
		dah_us = 24'(DAH_RESET_US);
		space_us = 24'(SPACE_RESET_US);
		end_us = 24'(END_RESET_US);
		errors = 0;
		checked = 0;
	endfunction

	function void set_threshold(reg_index_t idx, logic [23:0] v);
		case (idx)
			REG_DAH:   dah_us = v;
			REG_SPACE: space_us = v;
			REG_END:   end_us = v;
			default: ;
		endcase
	endfunction

	function logic [15:0] position_value(logic [2:0] pos, bit is_dah);
		int unsigned pos_scale[5];
		pos_scale = '{2, 20, 54, 104, 170};
		return 16'((is_dah ? DAH_WEIGHT : DIT_WEIGHT) * pos_scale[pos]);
	endfunction

	function logic [7:0] decode_letter();
		if (symbol_count == 3'd0 || symbol_count > MAX_SYMBOLS) begin
			return UNKNOWN_CHAR;
		end
		case (letter_code)
			16'd2150:  return "A";  16'd18884: return "B";  16'd18452: return "C";
			16'd7964:  return "D";  16'd210:   return "E";  16'd18468: return "F";
			16'd7804:  return "G";  16'd18900: return "H";  16'd2310:  return "I";
			16'd17476: return "J";  16'd7532:  return "K";  16'd18740: return "L";
			16'd2134:  return "M";  16'd2294:  return "N";  16'd7372:  return "O";
			16'd18308: return "P";  16'd17892: return "Q";  16'd7820:  return "R";
			16'd7980:  return "S";  16'd194:   return "T";  16'd7548:  return "U";
			16'd18068: return "V";  16'd7388:  return "W";  16'd18052: return "X";
			16'd17620: return "Y";  16'd18724: return "Z";  16'd33950: return "0";
			16'd33966: return "1";  16'd34126: return "2";  16'd34558: return "3";
			16'd35390: return "4";  16'd36750: return "5";  16'd36734: return "6";
			16'd36574: return "7";  16'd36142: return "8";  16'd35310: return "9";
			default:   return UNKNOWN_CHAR;
		endcase
	endfunction

	function void note_press(mode_t m, logic [23:0] len);
		logic [7:0] letter;
		if (m == MODE_KEY) begin
			if (symbol_count < MAX_SYMBOLS) begin
				letter_code = letter_code + position_value(symbol_count, len > dah_us);
				symbol_count = symbol_count + 3'd1;
			end else begin
				symbol_count = SAT_SYMBOLS;
			end
			return;
		end
		if (len > end_us) begin
			pending.push_back('{char_code: 8'd0, end_of_message: 1'b1, last: 1'b1});
		end else begin
			letter = decode_letter();
			if (len > space_us) begin
				pending.push_back('{char_code: letter, end_of_message: 1'b0, last: 1'b0});
				pending.push_back('{char_code: SPACE_CHAR, end_of_message: 1'b0, last: 1'b1});
			end else begin
				pending.push_back('{char_code: letter, end_of_message: 1'b0, last: 1'b1});
			end
		end
		letter_code = '0;
		symbol_count = '0;
	endfunction

	function void check_result(logic [7:0] ch, logic eom, logic lst);
		result_t want;
		if (pending.size() == 0) begin
			errors++;
			$display("%0t: unexpected item char_code=%h end_of_message=%b last=%b",
				$time, ch, eom, lst);
			return;
		end
		want = pending.pop_front();
		checked++;
		if (ch !== want.char_code) begin
			errors++;
			$display("%0t: char_code expected %h, got %h", $time, want.char_code, ch);
		end
		if (eom !== want.end_of_message) begin
			errors++;
			$display("%0t: end_of_message expected %b, got %b", $time,
				want.end_of_message, eom);
		end
		if (lst !== want.last) begin
			errors++;
			$display("%0t: last expected %b, got %b", $time, want.last, lst);
		end
	endfunction
endclass

module tb;
	localparam int unsigned MAX_LEN = 24'hFFFFFF;

	typedef enum int {
		BRK_SHORT,
		BRK_MEDIUM,
		BRK_LONG,
		BRK_ANY
	} break_kind_t;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [CFG_DATA_BITS-1:0] pwdata;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     in_valid;
	logic                     in_stall;
	logic                     mode;
	logic [23:0]              press_length_us;
	logic                     out_valid;
	logic                     out_stall;
	logic [7:0]               char_code;
	logic                     end_of_message;
	logic                     last;

	morse_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;

	string morse_patterns[36] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--..",
		"-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
		"---..", "----."
	};

	morse_key_timing_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.press_length_us(press_length_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_code(char_code),
		.end_of_message(end_of_message),
		.last(last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(char_code, end_of_message, last);
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic logic [23:0] len_between(int unsigned lo, int unsigned hi);
		case ($urandom_range(3))
			0:       return 24'(lo);
			1:       return 24'(hi);
			default: return 24'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic logic [23:0] dah_len();
		return (sb.dah_us < MAX_LEN) ? len_between(sb.dah_us + 1, MAX_LEN) : 24'(MAX_LEN);
	endfunction

	function automatic logic [23:0] break_len(break_kind_t kind);
		int unsigned lim;
		lim = (sb.space_us < sb.end_us) ? sb.space_us : sb.end_us;
		case (kind)
			BRK_SHORT: return len_between(0, lim);
			BRK_MEDIUM: begin
				if (sb.space_us < sb.end_us) begin
					return len_between(sb.space_us + 1, sb.end_us);
				end
				return len_between(0, lim);
			end
			BRK_LONG: begin
				return (sb.end_us < MAX_LEN) ? len_between(sb.end_us + 1, MAX_LEN)
					: 24'(MAX_LEN);
			end
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_press(mode_t m, logic [23:0] len);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		press_length_us <= len;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_press(m, len);
		items_sent++;
	endtask

	task automatic send_letter(int idx, break_kind_t kind);
		string pat;
		pat = morse_patterns[idx];
		for (int i = 0; i < pat.len(); i++) begin
			send_press(MODE_KEY, (pat[i] == "-") ? dah_len() : len_between(0, sb.dah_us));
		end
		send_press(MODE_BREAK, break_len(kind));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_threshold(reg_index_t idx, logic [23:0] v);
		logic [31:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {8'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		sb.set_threshold(idx, v);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== {8'd0, v}) begin
			sb.errors++;
			$display("%0t: register %s readback expected %h, got %h", $time, idx.name(),
				{8'd0, v}, rd);
		end
		@(posedge clk);
	endtask

	task automatic apply_thresholds(logic [23:0] d, logic [23:0] s, logic [23:0] e);
		wait_drained();
		write_threshold(REG_DAH, d);
		write_threshold(REG_SPACE, s);
		write_threshold(REG_END, e);
	endtask

	task automatic run_random(int count);
		int target;
		int r;
		target = items_sent + count;
		while (items_sent < target) begin
			r = $urandom_range(99);
			if (r < 78) begin
				send_letter($urandom_range(35), break_kind_t'($urandom_range(3)));
			end else if (r < 88) begin
				repeat ($urandom_range(7, 6)) send_press(MODE_KEY, 24'($urandom));
				send_press(MODE_BREAK, break_len(break_kind_t'($urandom_range(3))));
			end else begin
				send_press(mode_t'($urandom_range(1)), 24'($urandom));
			end
		end
	endtask

	initial begin
		#5_000_000;
		$display("** morse_key_timing_decoder_top: FAILED **");
		$finish;
	end

	initial begin
		sb = new();
		items_sent = 0;
		send_idle_pct = 23;
		recv_idle_pct = 71;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		mode = MODE_KEY;
		press_length_us = '0;
		out_stall = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_press(MODE_BREAK, 24'd0);
		send_press(MODE_KEY, 24'd0);
		send_press(MODE_KEY, 24'(DAH_RESET_US));
		send_press(MODE_BREAK, 24'(SPACE_RESET_US));
		send_press(MODE_KEY, 24'(DAH_RESET_US) + 24'd1);
		send_press(MODE_KEY, 24'(MAX_LEN));
		send_press(MODE_BREAK, 24'(SPACE_RESET_US) + 24'd1);
		send_press(MODE_KEY, 24'd0);
		send_press(MODE_BREAK, 24'(END_RESET_US));
		send_press(MODE_KEY, 24'(MAX_LEN));
		send_press(MODE_BREAK, 24'(END_RESET_US) + 24'd1);
		send_press(MODE_BREAK, 24'(MAX_LEN));
		repeat (6) send_press(MODE_KEY, 24'd0);
		send_press(MODE_BREAK, 24'd0);
		send_press(MODE_KEY, 24'd0);
		send_press(MODE_KEY, 24'd0);
		send_press(MODE_KEY, 24'(MAX_LEN));
		send_press(MODE_KEY, 24'(MAX_LEN));
		send_press(MODE_BREAK, 24'd0);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: apply_thresholds(24'd1000, 24'd2000, 24'd3000);
				1: apply_thresholds(24'd0, 24'd0, 24'd0);
				2: apply_thresholds(24'(MAX_LEN), 24'(MAX_LEN), 24'(MAX_LEN));
				3: apply_thresholds(24'($urandom_range(2000000)), 24'd5000000, 24'd1000000);
				4: apply_thresholds(24'($urandom), 24'($urandom), 24'($urandom));
				default: apply_thresholds(24'(DAH_RESET_US), 24'(SPACE_RESET_US),
					24'(END_RESET_US));
			endcase
			if (p < 2) begin
				send_idle_pct = 23;
				recv_idle_pct = 71;
			end else if (p < 4) begin
				send_idle_pct = 71;
				recv_idle_pct = 23;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			run_random(220);
		end

		wait_drained();
		$display("Sent %0d press items and checked %0d decoded items over seven threshold",
			items_sent, sb.checked);
		$display("settings, with stalls on either side and a stall-free stretch.");
		if (sb.errors == 0) begin
			$display("** morse_key_timing_decoder_top: PASSED **");
		end else begin
			$display("** morse_key_timing_decoder_top: FAILED **");
		end
		$finish;
	end
endmodule
